// ----- src/hs_pkg.sv -----
// ----------------------------------------------------------------------------
// hs_pkg
// Shared constants and types for the heap sorter.
// ----------------------------------------------------------------------------
package hs_pkg;

    localparam int DATA_W        = 32;
    localparam int MAX_ITEMS_DEF = 64;

    // result of one sift-down compare
    typedef struct packed {
        logic move;   // a child is larger than the sifted value
        logic right;  // that child is the right one
    } t_pick;

endpackage

// ----- src/hs_mem.sv -----
// ----------------------------------------------------------------------------
// hs_mem
// Element store: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module hs_mem #(
    parameter int DEPTH = hs_pkg::MAX_ITEMS_DEF,
    parameter int AW    = 6
) (
    input  logic                              i_clk,
    input  logic                              i_we,
    input  logic [AW-1:0]                     i_wa,
    input  logic signed [hs_pkg::DATA_W-1:0]  i_wd,
    input  logic [AW-1:0]                     i_ra_a,
    input  logic [AW-1:0]                     i_ra_b,
    output logic signed [hs_pkg::DATA_W-1:0]  o_rd_a,
    output logic signed [hs_pkg::DATA_W-1:0]  o_rd_b
);
    import hs_pkg::*;

    logic signed [DATA_W-1:0] r_mem [DEPTH];
    logic signed [DATA_W-1:0] r_rd_a;
    logic signed [DATA_W-1:0] r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wa] <= i_wd;
        end
        r_rd_a <= r_mem[i_ra_a];
        r_rd_b <= r_mem[i_ra_b];
    end

    assign o_rd_a = r_rd_a;
    assign o_rd_b = r_rd_b;

endmodule

// ----- src/hs_cmp.sv -----
// ----------------------------------------------------------------------------
// hs_cmp
// Shared compare unit: picks the largest of a node and its in-heap children.
// ----------------------------------------------------------------------------
module hs_cmp (
    input  logic signed [hs_pkg::DATA_W-1:0]  i_cur,
    input  logic signed [hs_pkg::DATA_W-1:0]  i_left,
    input  logic signed [hs_pkg::DATA_W-1:0]  i_right,
    input  logic                              i_left_ok,
    input  logic                              i_right_ok,
    output hs_pkg::t_pick                     o_pick,
    output logic signed [hs_pkg::DATA_W-1:0]  o_big
);
    import hs_pkg::*;

    logic signed [DATA_W-1:0] big_l;
    logic                     take_l;
    logic                     take_r;

    always_comb begin
        take_l = i_left_ok && (i_left > i_cur);
        big_l  = take_l ? i_left : i_cur;
        take_r = i_right_ok && (i_right > big_l);
        o_big        = take_r ? i_right : big_l;
        o_pick.move  = take_l || take_r;
        o_pick.right = take_r;
    end

endmodule

// ----- src/heap_sorter.sv -----
// ----------------------------------------------------------------------------
// heap_sorter
// Collects a set of signed values, heap-sorts it in place and returns it in
// ascending order.
// ----------------------------------------------------------------------------
//  channel | valid   | ready   | payload
//  --------+---------+---------+------------------------------------------
//  in      | i_valid | o_ready | i_value, i_last
//  out     | o_valid | i_ready | o_sorted_value, o_end_of_set, o_overflow
//
//  Loading accepts one beat per cycle. After the last beat the set is sorted
//  in place, one sift-down level at a time: both children are read from the
//  single store with two read ports and judged by the shared compare unit.
//  Each result is then read from the store, registered and held until the
//  sink takes it. Input is not ready while sorting or emitting. Reset is
//  synchronous, active low; the store is not cleared.
// ----------------------------------------------------------------------------
module heap_sorter #(
    parameter int MAX_ITEMS = hs_pkg::MAX_ITEMS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic signed [hs_pkg::DATA_W-1:0]  i_value,
    input  logic                              i_last,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [hs_pkg::DATA_W-1:0]  o_sorted_value,
    output logic                              o_end_of_set,
    output logic                              o_overflow
);
    import hs_pkg::*;

    localparam int AW    = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    localparam int CW    = AW + 2;

    typedef enum logic [8:0] {
        S_LOAD    = 9'b000000001,
        S_BLD_RD  = 9'b000000010,
        S_SD_LD   = 9'b000000100,
        S_SD_RD   = 9'b000001000,
        S_SD_CMP  = 9'b000010000,
        S_EX_RD   = 9'b000100000,
        S_EX_SW   = 9'b001000000,
        S_EMIT_RD = 9'b010000000,
        S_EMIT_WT = 9'b100000000
    } t_state;

    t_state                   r_state, n_state;
    logic [CNT_W-1:0]         r_cnt, n_cnt;
    logic [CNT_W-1:0]         r_tot, n_tot;
    logic [CNT_W-1:0]         r_len, n_len;
    logic [CNT_W-1:0]         r_k, n_k;
    logic [AW-1:0]            r_node, n_node;
    logic signed [DATA_W-1:0] r_cur, n_cur;
    logic                     r_drop, n_drop;
    logic                     r_bld, n_bld;
    logic                     r_out_valid, n_out_valid;
    logic signed [DATA_W-1:0] r_out_data, n_out_data;
    logic                     r_out_eos, n_out_eos;
    logic                     r_emit_ld, n_emit_ld;

    logic                     mem_we;
    logic [AW-1:0]            mem_wa;
    logic signed [DATA_W-1:0] mem_wd;
    logic [AW-1:0]            ra_a;
    logic [AW-1:0]            ra_b;
    logic signed [DATA_W-1:0] rd_a;
    logic signed [DATA_W-1:0] rd_b;

    logic [CW-1:0]            left_ix;
    logic [CW-1:0]            right_ix;
    logic                     left_ok;
    logic                     right_ok;
    t_pick                    pick;
    logic signed [DATA_W-1:0] big_val;
    logic [CNT_W-1:0]         k_dec;
    logic [CNT_W-1:0]         cnt_fin;
    logic                     sift_end;

    hs_mem #(
        .DEPTH (MAX_ITEMS),
        .AW    (AW)
    ) u_mem (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_wa   (mem_wa),
        .i_wd   (mem_wd),
        .i_ra_a (ra_a),
        .i_ra_b (ra_b),
        .o_rd_a (rd_a),
        .o_rd_b (rd_b)
    );

    hs_cmp u_cmp (
        .i_cur      (r_cur),
        .i_left     (rd_a),
        .i_right    (rd_b),
        .i_left_ok  (left_ok),
        .i_right_ok (right_ok),
        .o_pick     (pick),
        .o_big      (big_val)
    );

    assign left_ix  = {1'b0, r_node, 1'b1};
    assign right_ix = left_ix + CW'(1);
    assign left_ok  = left_ix  < CW'(r_len);
    assign right_ok = right_ix < CW'(r_len);
    assign k_dec    = r_k - CNT_W'(1);
    assign cnt_fin  = (r_cnt < CNT_W'(MAX_ITEMS)) ? r_cnt + CNT_W'(1) : r_cnt;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_tot       = r_tot;
        n_len       = r_len;
        n_k         = r_k;
        n_node      = r_node;
        n_cur       = r_cur;
        n_drop      = r_drop;
        n_bld       = r_bld;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        n_out_eos   = r_out_eos;
        n_emit_ld   = 1'b0;
        mem_we      = 1'b0;
        mem_wa      = r_node;
        mem_wd      = r_cur;
        ra_a        = r_node;
        ra_b        = r_node;
        sift_end    = 1'b0;

        unique case (r_state)
            S_LOAD: begin
                if (i_valid) begin
                    if (r_cnt < CNT_W'(MAX_ITEMS)) begin
                        mem_we = 1'b1;
                        mem_wa = r_cnt[AW-1:0];
                        mem_wd = i_value;
                        n_cnt  = r_cnt + CNT_W'(1);
                    end else begin
                        n_drop = 1'b1;
                    end
                    if (i_last) begin
                        n_cnt = '0;
                        n_tot = cnt_fin;
                        n_len = cnt_fin;
                        if (cnt_fin < CNT_W'(2)) begin
                            n_k     = '0;
                            n_state = S_EMIT_RD;
                        end else begin
                            n_bld   = 1'b1;
                            n_k     = cnt_fin >> 1;
                            n_state = S_BLD_RD;
                        end
                    end
                end
            end
            S_BLD_RD: begin
                ra_a    = k_dec[AW-1:0];
                n_node  = k_dec[AW-1:0];
                n_len   = r_tot;
                n_state = S_SD_LD;
            end
            S_SD_LD: begin
                n_cur   = rd_a;
                n_state = S_SD_RD;
            end
            S_SD_RD: begin
                if (!left_ok) begin
                    mem_we   = 1'b1;
                    sift_end = 1'b1;
                end else begin
                    ra_a    = left_ix[AW-1:0];
                    ra_b    = right_ix[AW-1:0];
                    n_state = S_SD_CMP;
                end
            end
            S_SD_CMP: begin
                mem_we = 1'b1;
                if (pick.move) begin
                    mem_wd  = big_val;
                    n_node  = pick.right ? right_ix[AW-1:0] : left_ix[AW-1:0];
                    n_state = S_SD_RD;
                end else begin
                    sift_end = 1'b1;
                end
            end
            S_EX_RD: begin
                ra_a    = '0;
                ra_b    = r_k[AW-1:0];
                n_state = S_EX_SW;
            end
            S_EX_SW: begin
                mem_we  = 1'b1;
                mem_wa  = r_k[AW-1:0];
                mem_wd  = rd_a;
                n_cur   = rd_b;
                n_node  = '0;
                n_len   = r_k;
                n_state = S_SD_RD;
            end
            S_EMIT_RD: begin
                ra_a      = r_k[AW-1:0];
                n_emit_ld = 1'b1;
                n_state   = S_EMIT_WT;
            end
            S_EMIT_WT: begin
                if (r_emit_ld) begin
                    n_out_valid = 1'b1;
                    n_out_data  = rd_a;
                    n_out_eos   = (r_k + CNT_W'(1)) == r_tot;
                end else if (i_ready) begin
                    n_out_valid = 1'b0;
                    if (r_out_eos) begin
                        n_drop  = 1'b0;
                        n_state = S_LOAD;
                    end else begin
                        n_k     = r_k + CNT_W'(1);
                        n_state = S_EMIT_RD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase

        if (sift_end) begin
            n_k = k_dec;
            if (r_bld) begin
                if (k_dec == '0) begin
                    n_bld   = 1'b0;
                    n_k     = r_tot - CNT_W'(1);
                    n_state = S_EX_RD;
                end else begin
                    n_state = S_BLD_RD;
                end
            end else if (k_dec == '0) begin
                n_state = S_EMIT_RD;
            end else begin
                n_state = S_EX_RD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_cnt       <= '0;
            r_drop      <= 1'b0;
            r_bld       <= 1'b0;
            r_out_valid <= 1'b0;
            r_emit_ld   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_drop      <= n_drop;
            r_bld       <= n_bld;
            r_out_valid <= n_out_valid;
            r_emit_ld   <= n_emit_ld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tot      <= n_tot;
        r_len      <= n_len;
        r_k        <= n_k;
        r_node     <= n_node;
        r_cur      <= n_cur;
        r_out_data <= n_out_data;
        r_out_eos  <= n_out_eos;
    end

    assign o_ready        = (r_state == S_LOAD);
    assign o_valid        = r_out_valid;
    assign o_sorted_value = r_out_data;
    assign o_end_of_set   = r_out_eos;
    assign o_overflow     = r_drop;

endmodule
